/* sv/psrg_pkg.sv */
package psrg_pkg;

	localparam int ID_W  = 32;
	localparam int SEQ_W = 32;

	// one table entry: sender in the low half, last accepted sequence above it
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [ID_W-1:0]  id;
	} entry_t;

	// outcome of comparing the pending word against one entry
	typedef struct packed {
		logic hit;    // sender matches
		logic newer;  // incoming sequence strictly above stored one
	} cmp_res_t;

endpackage

/* sv/psrg_table.sv */
module psrg_table import psrg_pkg::*; #(
	parameter int DEPTH = 8,
	parameter int IDX_W = 3
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	// contents undefined until written; only filled slots are ever looked at
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

/* sv/psrg_cmp.sv */
module psrg_cmp import psrg_pkg::*; (
	input  logic [ID_W-1:0]  key_id,
	input  logic [SEQ_W-1:0] key_seq,
	input  entry_t           entry,
	output cmp_res_t         res
);

	// plain unsigned compare, no wrap window
	always_comb begin
		res.hit   = (entry.id == key_id);
		res.newer = (key_seq > entry.seq);
	end

endmodule

/* sv/per_sender_replay_gate_unit.sv */
// With the gate off or the table empty the result is decided as the input word is taken;
//   otherwise the filled entries are scanned from slot 0 until a hit or the last one misses.
// The single compare unit walks one entry per cycle; a new word is taken only in ST_IDLE.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low, async): gate off, table empty, eviction pointer at slot 0;
//   table storage itself is not cleared.
module per_sender_replay_gate_unit import psrg_pkg::*; #(
	parameter int TABLE_DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: gate_enable
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] sender_id, [63:32] sequence_number
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] accepted, [7:1] zero
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a word
	localparam logic [1:0] ST_SCAN = 2'd1;  // walking the table, one entry per cycle
	localparam logic [1:0] ST_HOLD = 2'd2;  // result ready, output register still busy

	logic [1:0]       state_q, state_d;
	logic             gate_q;
	logic [CNT_W-1:0] cnt_q, cnt_d;       // filled slots
	logic [IDX_W-1:0] rp_q, rp_d;         // round-robin eviction slot
	logic [IDX_W-1:0] idx_q, idx_d;       // entry whose read data is on rd_data
	logic [ID_W-1:0]  key_id_q;
	logic [SEQ_W-1:0] key_seq_q;
	logic             res_q;
	logic             out_vld_q, out_acc_q;

	logic             s_acc, out_free, full;
	logic             fin, fin_res, load_out, load_res;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr, rd_addr, ins_slot, rp_next;
	logic [ID_W-1:0]  key_id;
	logic [SEQ_W-1:0] key_seq;
	entry_t           wr_data, rd_data;
	cmp_res_t         cmp;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;

	// in IDLE the word comes straight off the bus, later from the holding regs
	assign key_id  = (state_q == ST_IDLE) ? s_tdata[31:0]  : key_id_q;
	assign key_seq = (state_q == ST_IDLE) ? s_tdata[63:32] : key_seq_q;

	assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign ins_slot = full ? rp_q : cnt_q[IDX_W-1:0];
	assign rp_next  = (rp_q == IDX_W'(TABLE_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	// prefetch: entry 0 while idle, the following entry while scanning
	assign rd_addr = (state_q == ST_SCAN) ? idx_q + 1'b1 : '0;

	// update and insert both write {new seq, sender}; only the slot differs
	assign wr_data.id  = key_id;
	assign wr_data.seq = key_seq;

	psrg_table #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psrg_cmp u_cmp (
		.key_id  (key_id_q),
		.key_seq (key_seq_q),
		.entry   (rd_data),
		.res     (cmp)
	);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rp_d     = rp_q;
		idx_d    = idx_q;
		fin      = 1'b0;
		fin_res  = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = ins_slot;
		load_out = 1'b0;
		load_res = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (!gate_q) begin
						// gate off: reject, table untouched
						fin = 1'b1;
					end else if (cnt_q == '0) begin
						// empty table: new sender goes to slot 0
						fin     = 1'b1;
						fin_res = 1'b1;
						wr_en   = 1'b1;
						cnt_d   = cnt_q + 1'b1;
					end else begin
						state_d = ST_SCAN;
						idx_d   = '0;
					end
				end
			end
			ST_SCAN: begin
				if (cmp.hit) begin
					// known sender: accept only a strictly newer sequence
					fin     = 1'b1;
					fin_res = cmp.newer;
					wr_en   = cmp.newer;
					wr_addr = idx_q;
				end else if (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) begin
					// last filled entry missed: insert, or evict once full
					fin     = 1'b1;
					fin_res = 1'b1;
					wr_en   = 1'b1;
					if (full) begin
						rp_d = rp_next;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			load_res = 1'b1;
			if (out_free) begin
				load_out = 1'b1;
				state_d  = ST_IDLE;
			end else begin
				state_d = ST_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			gate_q    <= 1'b0;
			cnt_q     <= '0;
			rp_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rp_q    <= rp_d;
			if (cfg_valid && cfg_ready) begin
				gate_q <= cfg_data[0];
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (s_acc) begin
			key_id_q  <= s_tdata[31:0];
			key_seq_q <= s_tdata[63:32];
		end
		if (load_res) begin
			res_q <= fin_res;
		end
		if (load_out) begin
			out_acc_q <= fin ? fin_res : res_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'b0, out_acc_q};

endmodule

/* sv/psrg_checker.sv */
module psrg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	logic [1:0] pend_q;  // words taken but not yet delivered
	logic       s_acc, m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (s_acc && !m_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (m_acc && !s_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// no result without a word behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result with no word outstanding");

	// one word in the output register, at most one more in work
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3 && !(pend_q == 2'd2 && s_tready))
		else $error("too many words in flight");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'd0)
		else $error("nonzero padding in result");

	// reset empties the output
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind per_sender_replay_gate_unit psrg_checker u_psrg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
